>>> rtl/ppq_pkg.sv
package ppq_pkg;

  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 3;

  localparam logic [PRIO_W-1:0] IDLE_PRIO_RESET = 16'd9999;

  localparam logic [ACTION_W-1:0] ACT_ADD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POLL = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DONE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NONE = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NEST = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_IDLE = 3'd4;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

endpackage

>>> rtl/ppq_ram.sv
module ppq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/preemptive_priority_task_queue_top.sv
// flow: an add runs the compare/shift state, the write state or both, a poll the check state,
// a done the stack read state; a full-queue add, an empty poll, an idle done or any other action goes to S_FIN
// throughput: one word at a time; the sorted insert walks the queue ram one entry per
// cycle, which sets the add time; a stalled result word holds off the next word
// reset: queue and nesting stack empty, running level 9999; ram contents are
// not cleared since only entries below the fill level are ever read
module preemptive_priority_task_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned NEST_LIMIT  = 8,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OUT_BITS = 1 + ppq_pkg::HANDLE_W + 3 * ppq_pkg::PRIO_W / 1
                                     - ppq_pkg::PRIO_W + CW + ppq_pkg::STATUS_W,
  localparam int unsigned OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ppq_pkg::PRIO_W-1:0]         cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // task_handle, task_priority
  input  logic [47:0]                        s_axis_tdata,
  // action
  input  logic [ppq_pkg::ACTION_W-1:0]       s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // dispatched, out_handle, out_priority, running_level, pending_count, status
  output logic [OUT_W-1:0]                   m_axis_tdata
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned DW = $clog2(NEST_LIMIT + 1);
  localparam int unsigned NW = (NEST_LIMIT > 1) ? $clog2(NEST_LIMIT) : 1;
  localparam int unsigned PW = ppq_pkg::PRIO_W;
  localparam int unsigned HW = ppq_pkg::HANDLE_W;
  localparam int unsigned TW = ppq_pkg::STATUS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_WR,
    S_POLL_CHK,
    S_DONE_RD,
    S_FIN
  } state_e;

  state_e             state_q, state_d;
  logic [PW-1:0]      cur_q, cur_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      head_q, head_d;
  logic [DW-1:0]      nest_q, nest_d;
  logic [CW-1:0]      k_q, k_d;
  ppq_pkg::entry_t    new_q, new_d;
  logic               res_disp_q, res_disp_d;
  ppq_pkg::entry_t    res_ent_q, res_ent_d;
  logic [TW-1:0]      res_stat_q, res_stat_d;

  logic               out_valid_q;
  logic               out_disp_q;
  ppq_pkg::entry_t    out_ent_q;
  logic [PW-1:0]      out_level_q;
  logic [CW-1:0]      out_count_q;
  logic [TW-1:0]      out_stat_q;
  logic               out_load;

  logic               q_we;
  logic [AW-1:0]      q_waddr;
  ppq_pkg::entry_t    q_wdata;
  logic [AW-1:0]      q_raddr;
  ppq_pkg::entry_t    q_rdata;

  logic               s_we;
  logic [PW-1:0]      s_rdata;
  logic [DW-1:0]      nest_dec;
  logic [NW-1:0]      s_waddr;
  logic [NW-1:0]      s_raddr;

  logic               in_acc;

  // logical queue position to ram address, queue is a ring starting at head
  function automatic logic [AW-1:0] phys(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  ppq_ram #(
    .WIDTH($bits(ppq_pkg::entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(q_waddr),
    .wdata_i(q_wdata),
    .raddr_i(q_raddr),
    .rdata_o(q_rdata)
  );

  assign nest_dec = nest_q - DW'(1);
  assign s_waddr  = nest_q[NW-1:0];
  assign s_raddr  = nest_dec[NW-1:0];

  ppq_ram #(
    .WIDTH(PW),
    .DEPTH(NEST_LIMIT)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(cur_q),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_load      = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    count_d    = count_q;
    head_d     = head_q;
    nest_d     = nest_q;
    k_d        = k_q;
    new_d      = new_q;
    res_disp_d = res_disp_q;
    res_ent_d  = res_ent_q;
    res_stat_d = res_stat_q;
    q_we       = 1'b0;
    q_waddr    = phys(head_q, k_q);
    q_wdata    = new_q;
    q_raddr    = head_q;
    s_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          new_d.handle = s_axis_tdata[HW-1:0];
          new_d.prio   = s_axis_tdata[HW+PW-1:HW];
          res_disp_d   = 1'b0;
          res_ent_d    = '0;
          res_stat_d   = ppq_pkg::STAT_OK;
          state_d      = S_FIN;
          case (s_axis_tuser)
            ppq_pkg::ACT_ADD: begin
              if (count_q == CW'(QUEUE_DEPTH)) begin
                res_stat_d = ppq_pkg::STAT_FULL;
              end else if (count_q == '0) begin
                k_d     = '0;
                state_d = S_INS_WR;
              end else begin
                k_d     = count_q;
                q_raddr = phys(head_q, count_q - CW'(1));
                state_d = S_INS_CMP;
              end
            end
            ppq_pkg::ACT_POLL: begin
              if (count_q == '0) begin
                res_stat_d = ppq_pkg::STAT_NONE;
              end else begin
                q_raddr = head_q;
                state_d = S_POLL_CHK;
              end
            end
            ppq_pkg::ACT_DONE: begin
              if (nest_q == '0) begin
                res_stat_d = ppq_pkg::STAT_IDLE;
              end else begin
                state_d = S_DONE_RD;
              end
            end
            default: begin
              res_stat_d = ppq_pkg::STAT_OK;
            end
          endcase
        end
      end
      S_INS_CMP: begin
        // entry at k-1 is in q_rdata; shift it up while strictly less urgent
        q_we = 1'b1;
        if (q_rdata.prio > new_q.prio) begin
          q_wdata = q_rdata;
          k_d     = k_q - CW'(1);
          if (k_q == CW'(1)) begin
            state_d = S_INS_WR;
          end else begin
            q_raddr = phys(head_q, k_q - CW'(2));
          end
        end else begin
          count_d = count_q + CW'(1);
          state_d = S_FIN;
        end
      end
      S_INS_WR: begin
        q_we    = 1'b1;
        count_d = count_q + CW'(1);
        state_d = S_FIN;
      end
      S_POLL_CHK: begin
        state_d = S_FIN;
        if (q_rdata.prio >= cur_q) begin
          res_stat_d = ppq_pkg::STAT_NONE;
        end else if (nest_q >= DW'(NEST_LIMIT)) begin
          res_stat_d = ppq_pkg::STAT_NEST;
        end else begin
          s_we       = 1'b1;
          nest_d     = nest_q + DW'(1);
          cur_d      = q_rdata.prio;
          count_d    = count_q - CW'(1);
          head_d     = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
          res_disp_d = 1'b1;
          res_ent_d  = q_rdata;
        end
      end
      S_DONE_RD: begin
        cur_d   = s_rdata;
        nest_d  = nest_dec;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // running level follows the idle register only with no task active
    if (cfg_valid_i && (nest_q == '0)) begin
      cur_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= ppq_pkg::IDLE_PRIO_RESET;
      count_q     <= '0;
      head_q      <= '0;
      nest_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      count_q <= count_d;
      head_q  <= head_d;
      nest_q  <= nest_d;
      k_q     <= k_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    new_q      <= new_d;
    res_disp_q <= res_disp_d;
    res_ent_q  <= res_ent_d;
    res_stat_q <= res_stat_d;
    if (out_load) begin
      out_disp_q  <= res_disp_q;
      out_ent_q   <= res_ent_q;
      out_level_q <= cur_q;
      out_count_q <= count_q;
      out_stat_q  <= res_stat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_stat_q, out_count_q, out_level_q,
                                 out_ent_q.prio, out_ent_q.handle, out_disp_q});

endmodule
